/* design/pbc_pkg.sv */
package pbc_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int LEN_WIDTH   = COORD_WIDTH - 1;
   localparam int EXT_WIDTH   = COORD_WIDTH + 2;
   localparam int NUM_AXES    = 3;
   localparam int FLAG_WIDTH  = 2 * NUM_AXES;
   localparam int CSR_IDX_WIDTH = 3;

   localparam logic [LEN_WIDTH-1:0] LEN_RESET = LEN_WIDTH'(64) << FRAC_BITS;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = ~COORD_MIN;

   // boundary mode codes, two bits per axis
   localparam logic [1:0] MODE_PERIODIC   = 2'd0;
   localparam logic [1:0] MODE_REFLECTING = 2'd1;
   localparam logic [1:0] MODE_ABSORBING  = 2'd2;
   localparam logic [1:0] MODE_ABSORB_ALT = 2'd3;

   localparam logic signed [1:0] DIR_STAY = 2'sb00;
   localparam logic signed [1:0] DIR_HIGH = 2'sb01;
   localparam logic signed [1:0] DIR_LOW  = 2'sb11;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LENGTH_X        = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LENGTH_Y        = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LENGTH_Z        = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NEIGHBOUR_FLAGS = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LOW_MODES       = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HIGH_MODES      = 3'd5;

   typedef struct packed {
      logic [LEN_WIDTH-1:0] len;
      logic                 lo_nb;
      logic                 hi_nb;
      logic [1:0]           lo_mode;
      logic [1:0]           hi_mode;
   } axis_cfg_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos;
      logic signed [COORD_WIDTH-1:0] mom;
      logic signed [1:0]             dir;
      logic                          drop;
   } lane_res_type;

   // clamp an extended value into [0, len - 1]
   function automatic logic signed [COORD_WIDTH-1:0] clamp_in(
      input logic signed [EXT_WIDTH-1:0] v,
      input logic signed [EXT_WIDTH-1:0] len
   );
      logic signed [EXT_WIDTH-1:0] r;
      if (v < 0)
         r = '0;
      else if (v >= len)
         r = len - EXT_WIDTH'(1);
      else
         r = v;
      return r[COORD_WIDTH-1:0];
   endfunction

endpackage

/* design/pbc_lane.sv */
module pbc_lane
   import pbc_pkg::*;
(
   input  logic                          clock,
   input  logic signed [COORD_WIDTH-1:0] pos,
   input  logic signed [COORD_WIDTH-1:0] mom,
   input  axis_cfg_type                  cfg,
   output lane_res_type                  res
);

   logic signed [EXT_WIDTH-1:0] len_e;
   logic signed [EXT_WIDTH-1:0] pos_e;
   logic signed [EXT_WIDTH-1:0] lo_wrap;
   logic signed [EXT_WIDTH-1:0] lo_refl;
   logic signed [EXT_WIDTH-1:0] hi_wrap;
   logic signed [EXT_WIDTH-1:0] hi_refl;
   logic signed [COORD_WIDTH-1:0] mom_neg;
   lane_res_type res_in;
   lane_res_type res_ff;

   always_comb begin
      len_e   = (cfg.len == '0) ? EXT_WIDTH'(1) : {3'b000, cfg.len};
      pos_e   = {{2{pos[COORD_WIDTH-1]}}, pos};
      lo_wrap = pos_e + len_e;
      lo_refl = -pos_e;
      hi_wrap = pos_e - len_e;
      hi_refl = (len_e <<< 1) - pos_e;
      mom_neg = (mom == COORD_MIN) ? COORD_MAX : -mom;

      res_in.pos  = pos;
      res_in.mom  = mom;
      res_in.dir  = DIR_STAY;
      res_in.drop = 1'b0;

      if (pos_e < 0) begin
         if (cfg.lo_nb || cfg.lo_mode == MODE_PERIODIC) begin
            res_in.pos = clamp_in(lo_wrap, len_e);
            res_in.dir = DIR_LOW;
         end else if (cfg.lo_mode == MODE_REFLECTING) begin
            res_in.pos = (lo_refl >= len_e) ? clamp_in(len_e - EXT_WIDTH'(1), len_e)
                                            : lo_refl[COORD_WIDTH-1:0];
            res_in.mom = mom_neg;
         end else begin
            res_in.drop = 1'b1;
         end
      end else if (pos_e >= len_e) begin
         if (cfg.hi_nb || cfg.hi_mode == MODE_PERIODIC) begin
            res_in.pos = clamp_in(hi_wrap, len_e);
            res_in.dir = DIR_HIGH;
         end else if (cfg.hi_mode == MODE_REFLECTING) begin
            res_in.pos = clamp_in(hi_refl, len_e);
            res_in.mom = mom_neg;
         end else begin
            res_in.drop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

/* design/pbc_merge.sv */
module pbc_merge
   import pbc_pkg::*;
(
   input  logic                          clock,
   input  lane_res_type                  lane_res [NUM_AXES],
   output logic signed [COORD_WIDTH-1:0] new_pos  [NUM_AXES],
   output logic signed [COORD_WIDTH-1:0] new_mom  [NUM_AXES],
   output logic signed [1:0]             dir      [NUM_AXES],
   output logic                          dropped
);

   logic                          drop_any;
   logic signed [COORD_WIDTH-1:0] pos_ff [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] mom_ff [NUM_AXES];
   logic signed [1:0]             dir_ff [NUM_AXES];
   logic                          dropped_ff;

   always_comb begin
      drop_any = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         drop_any = drop_any | lane_res[a].drop;
      end
   end

   // absorbed particles come out all zero
   always_ff @(posedge clock) begin
      for (int a = 0; a < NUM_AXES; a++) begin
         pos_ff[a] <= drop_any ? '0 : lane_res[a].pos;
         mom_ff[a] <= drop_any ? '0 : lane_res[a].mom;
         dir_ff[a] <= drop_any ? DIR_STAY : lane_res[a].dir;
      end
      dropped_ff <= drop_any;
   end

   assign new_pos = pos_ff;
   assign new_mom = mom_ff;
   assign dir     = dir_ff;
   assign dropped = dropped_ff;

endmodule

/* design/particle_boundary_classifier_unit.sv */
// channel  | handshake         | beat
// ---------+-------------------+-------------------------------------------------
// req      | start & !busy     | req_pos_x/y/z, req_mom_x/y/z
// rsp      | rsp_valid         | rsp_new_pos/mom_x/y/z, rsp_dir_x/y/z, rsp_dropped
// csr      | csr_we            | csr_index, csr_wdata
//
// One beat per cycle; the result is registered in the axis lanes, then in the merge.
// busy stays low, a new particle may start every cycle.
// Synchronous reset clears strobes and loads default lengths, flags and modes.
// No stall: rsp beats are shown for exactly one cycle.
module particle_boundary_classifier_unit
   import pbc_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [COORD_WIDTH-1:0]   req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]   req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]   req_pos_z,
   input  logic signed [COORD_WIDTH-1:0]   req_mom_x,
   input  logic signed [COORD_WIDTH-1:0]   req_mom_y,
   input  logic signed [COORD_WIDTH-1:0]   req_mom_z,
   output logic                            rsp_valid,
   output logic signed [COORD_WIDTH-1:0]   rsp_new_pos_x,
   output logic signed [COORD_WIDTH-1:0]   rsp_new_pos_y,
   output logic signed [COORD_WIDTH-1:0]   rsp_new_pos_z,
   output logic signed [COORD_WIDTH-1:0]   rsp_new_mom_x,
   output logic signed [COORD_WIDTH-1:0]   rsp_new_mom_y,
   output logic signed [COORD_WIDTH-1:0]   rsp_new_mom_z,
   output logic signed [1:0]               rsp_dir_x,
   output logic signed [1:0]               rsp_dir_y,
   output logic signed [1:0]               rsp_dir_z,
   output logic                            rsp_dropped,
   input  logic                            csr_we,
   input  logic [CSR_IDX_WIDTH-1:0]        csr_index,
   input  logic [LEN_WIDTH-1:0]            csr_wdata
);

   logic [LEN_WIDTH-1:0]  length_ff [NUM_AXES];
   logic [FLAG_WIDTH-1:0] nb_flags_ff;
   logic [FLAG_WIDTH-1:0] low_modes_ff;
   logic [FLAG_WIDTH-1:0] high_modes_ff;
   logic                  s1_valid_ff;
   logic                  s2_valid_ff;

   logic signed [COORD_WIDTH-1:0] pos_in [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] mom_in [NUM_AXES];
   axis_cfg_type                  axis_cfg [NUM_AXES];
   lane_res_type                  lane_res [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] new_pos [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] new_mom [NUM_AXES];
   logic signed [1:0]             new_dir [NUM_AXES];
   logic                          dropped;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            length_ff[a] <= LEN_RESET;
         end
         nb_flags_ff   <= '0;
         low_modes_ff  <= '0;
         high_modes_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LENGTH_X:        length_ff[0]  <= csr_wdata[LEN_WIDTH-1:0];
            CSR_LENGTH_Y:        length_ff[1]  <= csr_wdata[LEN_WIDTH-1:0];
            CSR_LENGTH_Z:        length_ff[2]  <= csr_wdata[LEN_WIDTH-1:0];
            CSR_NEIGHBOUR_FLAGS: nb_flags_ff   <= csr_wdata[FLAG_WIDTH-1:0];
            CSR_LOW_MODES:       low_modes_ff  <= csr_wdata[FLAG_WIDTH-1:0];
            CSR_HIGH_MODES:      high_modes_ff <= csr_wdata[FLAG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign pos_in[0] = req_pos_x;
   assign pos_in[1] = req_pos_y;
   assign pos_in[2] = req_pos_z;
   assign mom_in[0] = req_mom_x;
   assign mom_in[1] = req_mom_y;
   assign mom_in[2] = req_mom_z;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      assign axis_cfg[a].len     = length_ff[a];
      assign axis_cfg[a].lo_nb   = nb_flags_ff[a];
      assign axis_cfg[a].hi_nb   = nb_flags_ff[NUM_AXES + a];
      assign axis_cfg[a].lo_mode = low_modes_ff[2*a +: 2];
      assign axis_cfg[a].hi_mode = high_modes_ff[2*a +: 2];

      pbc_lane u_lane (
         .clock (clock),
         .pos   (pos_in[a]),
         .mom   (mom_in[a]),
         .cfg   (axis_cfg[a]),
         .res   (lane_res[a])
      );
   end

   pbc_merge u_merge (
      .clock    (clock),
      .lane_res (lane_res),
      .new_pos  (new_pos),
      .new_mom  (new_mom),
      .dir      (new_dir),
      .dropped  (dropped)
   );

   assign rsp_valid     = s2_valid_ff;
   assign rsp_new_pos_x = new_pos[0];
   assign rsp_new_pos_y = new_pos[1];
   assign rsp_new_pos_z = new_pos[2];
   assign rsp_new_mom_x = new_mom[0];
   assign rsp_new_mom_y = new_mom[1];
   assign rsp_new_mom_z = new_mom[2];
   assign rsp_dir_x     = new_dir[0];
   assign rsp_dir_y     = new_dir[1];
   assign rsp_dir_z     = new_dir[2];
   assign rsp_dropped   = dropped;

   a_rsp_follows_start : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(s1_valid_ff))
      else $error("rsp beat without a started particle");

   a_drop_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_dir_x == DIR_STAY && rsp_dir_y == DIR_STAY
                                   && rsp_dir_z == DIR_STAY && rsp_new_pos_x == 0
                                   && rsp_new_mom_x == 0)
      else $error("dropped beat carries nonzero fields");

   a_pos_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dropped && rsp_dir_x != DIR_STAY |->
         !rsp_new_pos_x[COORD_WIDTH-1] && rsp_dir_x != 2'sb10)
      else $error("wrapped x position out of patch");

endmodule

/* tb/sv/particle_boundary_checker.sv */
module particle_boundary_checker
   import pbc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic signed [COORD_WIDTH-1:0] req_mom_x,
   input  logic signed [COORD_WIDTH-1:0] req_mom_y,
   input  logic signed [COORD_WIDTH-1:0] req_mom_z,
   input  logic                          rsp_valid,
   input  logic signed [COORD_WIDTH-1:0] rsp_new_pos_x,
   input  logic signed [COORD_WIDTH-1:0] rsp_new_pos_y,
   input  logic signed [COORD_WIDTH-1:0] rsp_new_pos_z,
   input  logic signed [COORD_WIDTH-1:0] rsp_new_mom_x,
   input  logic signed [COORD_WIDTH-1:0] rsp_new_mom_y,
   input  logic signed [COORD_WIDTH-1:0] rsp_new_mom_z,
   input  logic signed [1:0]             rsp_dir_x,
   input  logic signed [1:0]             rsp_dir_y,
   input  logic signed [1:0]             rsp_dir_z,
   input  logic                          rsp_dropped,
   input  logic                          csr_we,
   input  logic [CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [LEN_WIDTH-1:0]          csr_wdata,
   output int                            mismatch_count,
   output int                            outstanding
);

   typedef struct packed {
      logic [NUM_AXES-1:0][COORD_WIDTH-1:0] pos;
      logic [NUM_AXES-1:0][COORD_WIDTH-1:0] mom;
      logic [NUM_AXES-1:0][1:0]             dir;
      logic                                 dropped;
   } particle_out_type;

   logic [LEN_WIDTH-1:0]  axis_len [NUM_AXES];
   logic [FLAG_WIDTH-1:0] nb_flags;
   logic [FLAG_WIDTH-1:0] low_modes;
   logic [FLAG_WIDTH-1:0] high_modes;
   particle_out_type      expected_q [$];
   string                 axis_tag [NUM_AXES] = '{"x", "y", "z"};

   function automatic longint fold_into_patch(input longint v, input longint len);
      if (v < 0)
         return 0;
      if (v >= len)
         return len - 1;
      return v;
   endfunction

   function automatic particle_out_type resolve_boundaries(
      input logic signed [COORD_WIDTH-1:0] pos_in [NUM_AXES],
      input logic signed [COORD_WIDTH-1:0] mom_in [NUM_AXES]
   );
      particle_out_type r;
      longint           len;
      longint           p;
      longint           m;
      logic [1:0]       lo_mode;
      logic [1:0]       hi_mode;
      logic             lo_nb;
      logic             hi_nb;
      logic signed [1:0] d;
      logic             drop;
      r = '0;
      drop = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         len = axis_len[a];
         if (len == 0)
            len = 1;
         p = pos_in[a];
         m = mom_in[a];
         lo_mode = low_modes[2*a +: 2];
         hi_mode = high_modes[2*a +: 2];
         lo_nb = nb_flags[a];
         hi_nb = nb_flags[NUM_AXES + a];
         d = DIR_STAY;
         if (p < 0) begin
            if (lo_nb || lo_mode == MODE_PERIODIC) begin
               p = fold_into_patch(p + len, len);
               d = DIR_LOW;
            end else if (lo_mode == MODE_REFLECTING) begin
               p = (p <= -len) ? len - 1 : -p;
               m = (mom_in[a] == COORD_MIN) ? longint'(COORD_MAX) : -m;
            end else begin
               drop = 1'b1;
            end
         end else if (p >= len) begin
            if (hi_nb || hi_mode == MODE_PERIODIC) begin
               p = fold_into_patch(p - len, len);
               d = DIR_HIGH;
            end else if (hi_mode == MODE_REFLECTING) begin
               p = fold_into_patch(2 * len - p, len);
               m = (mom_in[a] == COORD_MIN) ? longint'(COORD_MAX) : -m;
            end else begin
               drop = 1'b1;
            end
         end
         if (p > longint'(COORD_MAX))
            p = COORD_MAX;
         r.pos[a] = p[COORD_WIDTH-1:0];
         r.mom[a] = m[COORD_WIDTH-1:0];
         r.dir[a] = d;
      end
      if (drop) begin
         r = '0;
         r.dropped = 1'b1;
      end
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [COORD_WIDTH-1:0] want,
                                input logic [COORD_WIDTH-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      logic signed [COORD_WIDTH-1:0] pin [NUM_AXES];
      logic signed [COORD_WIDTH-1:0] min [NUM_AXES];
      particle_out_type got;
      particle_out_type want;
      if (reset) begin
         expected_q.delete();
         mismatch_count = 0;
         outstanding <= 0;
         for (int a = 0; a < NUM_AXES; a++)
            axis_len[a] <= LEN_RESET;
         nb_flags <= '0;
         low_modes <= '0;
         high_modes <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LENGTH_X:        axis_len[0] <= csr_wdata[LEN_WIDTH-1:0];
               CSR_LENGTH_Y:        axis_len[1] <= csr_wdata[LEN_WIDTH-1:0];
               CSR_LENGTH_Z:        axis_len[2] <= csr_wdata[LEN_WIDTH-1:0];
               CSR_NEIGHBOUR_FLAGS: nb_flags <= csr_wdata[FLAG_WIDTH-1:0];
               CSR_LOW_MODES:       low_modes <= csr_wdata[FLAG_WIDTH-1:0];
               CSR_HIGH_MODES:      high_modes <= csr_wdata[FLAG_WIDTH-1:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            got.pos[0] = rsp_new_pos_x;
            got.pos[1] = rsp_new_pos_y;
            got.pos[2] = rsp_new_pos_z;
            got.mom[0] = rsp_new_mom_x;
            got.mom[1] = rsp_new_mom_y;
            got.mom[2] = rsp_new_mom_z;
            got.dir[0] = rsp_dir_x;
            got.dir[1] = rsp_dir_y;
            got.dir[2] = rsp_dir_z;
            got.dropped = rsp_dropped;
            if (expected_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected rsp beat, nothing pending (dropped %b)",
                        $time, rsp_dropped);
            end else begin
               want = expected_q.pop_front();
               for (int a = 0; a < NUM_AXES; a++) begin
                  compare_field({"new_pos_", axis_tag[a]}, want.pos[a], got.pos[a]);
                  compare_field({"new_mom_", axis_tag[a]}, want.mom[a], got.mom[a]);
                  compare_field({"dir_", axis_tag[a]}, COORD_WIDTH'(want.dir[a]),
                                COORD_WIDTH'(got.dir[a]));
               end
               compare_field("dropped", COORD_WIDTH'(want.dropped),
                             COORD_WIDTH'(got.dropped));
            end
         end
         if (start && !busy) begin
            pin = '{req_pos_x, req_pos_y, req_pos_z};
            min = '{req_mom_x, req_mom_y, req_mom_z};
            expected_q.push_back(resolve_boundaries(pin, min));
         end
         outstanding <= expected_q.size();
      end
   end

endmodule

/* tb/sv/particle_boundary_classifier_unit_tb.sv */
module particle_boundary_classifier_unit_tb;
   import pbc_pkg::*;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_UNMAPPED_HI = 3'd7;
   localparam logic signed [COORD_WIDTH-1:0] RESET_SPAN = COORD_WIDTH'(LEN_RESET);
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_ITEMS    = 127;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic signed [COORD_WIDTH-1:0] req_pos_x = '0;
   logic signed [COORD_WIDTH-1:0] req_pos_y = '0;
   logic signed [COORD_WIDTH-1:0] req_pos_z = '0;
   logic signed [COORD_WIDTH-1:0] req_mom_x = '0;
   logic signed [COORD_WIDTH-1:0] req_mom_y = '0;
   logic signed [COORD_WIDTH-1:0] req_mom_z = '0;
   logic                          rsp_valid;
   logic signed [COORD_WIDTH-1:0] rsp_new_pos_x;
   logic signed [COORD_WIDTH-1:0] rsp_new_pos_y;
   logic signed [COORD_WIDTH-1:0] rsp_new_pos_z;
   logic signed [COORD_WIDTH-1:0] rsp_new_mom_x;
   logic signed [COORD_WIDTH-1:0] rsp_new_mom_y;
   logic signed [COORD_WIDTH-1:0] rsp_new_mom_z;
   logic signed [1:0]             rsp_dir_x;
   logic signed [1:0]             rsp_dir_y;
   logic signed [1:0]             rsp_dir_z;
   logic                          rsp_dropped;
   logic                          csr_we = 1'b0;
   logic [CSR_IDX_WIDTH-1:0]      csr_index = '0;
   logic [LEN_WIDTH-1:0]          csr_wdata = '0;
   int                            mismatch_count;
   int                            outstanding;

   longint patch_len [NUM_AXES] = '{LEN_RESET, LEN_RESET, LEN_RESET};
   bit     idle_on;
   int     items_sent;
   int     settings_count = 1;
   int     dropped_seen;
   int     quiet_cycles;

   particle_boundary_classifier_unit u_top (.*);

   particle_boundary_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // progress watchdog: counts cycles with neither an accepted req nor a rsp beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_dropped)
            dropped_seen++;
         if ((start && !busy) || rsp_valid)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no progress for %0d cycles", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [COORD_WIDTH-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[LEN_WIDTH-1:0];
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [COORD_WIDTH-1:0] lx, input logic [COORD_WIDTH-1:0] ly,
                                input logic [COORD_WIDTH-1:0] lz, input logic [COORD_WIDTH-1:0] nb,
                                input logic [COORD_WIDTH-1:0] lo, input logic [COORD_WIDTH-1:0] hi);
      logic [COORD_WIDTH-1:0] raw [NUM_AXES];
      raw = '{lx, ly, lz};
      write_csr(CSR_LENGTH_X, lx);
      write_csr(CSR_LENGTH_Y, ly);
      write_csr(CSR_LENGTH_Z, lz);
      write_csr(CSR_NEIGHBOUR_FLAGS, nb);
      write_csr(CSR_LOW_MODES, lo);
      write_csr(CSR_HIGH_MODES, hi);
      write_csr($urandom_range(0, 1) ? CSR_UNMAPPED_LO : CSR_UNMAPPED_HI, $urandom);
      csr_we <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         patch_len[a] = raw[a][LEN_WIDTH-1:0];
         if (patch_len[a] == 0)
            patch_len[a] = 1;
      end
      settings_count++;
   endtask

   task automatic send_particle(input logic signed [COORD_WIDTH-1:0] px,
                                input logic signed [COORD_WIDTH-1:0] py,
                                input logic signed [COORD_WIDTH-1:0] pz,
                                input logic signed [COORD_WIDTH-1:0] mx,
                                input logic signed [COORD_WIDTH-1:0] my,
                                input logic signed [COORD_WIDTH-1:0] mz);
      start <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_mom_x <= mx;
      req_mom_y <= my;
      req_mom_z <= mz;
      do @(posedge clock); while (busy);
      items_sent++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // hold off until every pending rsp beat has come back, then let the pipe empty
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [COORD_WIDTH-1:0] pick_coord(input int a);
      longint len;
      longint v;
      len = patch_len[a];
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = longint'($urandom_range(0, 32'(len - 1)));
         4: v = -longint'($urandom_range(1, 32'(len)));
         5: v = len + longint'($urandom_range(0, 32'(len)));
         6: v = longint'($urandom);
         7: begin
            case ($urandom_range(0, 7))
               0: v = COORD_MIN;
               1: v = COORD_MAX;
               2: v = len;
               3: v = len - 1;
               4: v = 2 * len;
               5: v = -len;
               6: v = -len - 1;
               default: v = -1;
            endcase
         end
         8: v = len + longint'($urandom_range(0, 3)) - 2;
         default: v = -longint'($urandom_range(1, 4));
      endcase
      return v[COORD_WIDTH-1:0];
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] pick_mom();
      case ($urandom_range(0, 7))
         0: return COORD_MIN;
         1: return COORD_MAX;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [COORD_WIDTH-1:0] pick_length();
      case ($urandom_range(0, 7))
         0: return 1;
         1: return 0;
         2: return 32'h7FFF_FFFF;
         3: return 32'hFFFF_FFFF;
         4: return COORD_WIDTH'(LEN_RESET);
         5: return $urandom_range(1, 1 << 20);
         6: return $urandom;
         default: return $urandom_range(2, 64) << FRAC_BITS;
      endcase
   endfunction

   function automatic logic [COORD_WIDTH-1:0] pick_flag_word();
      logic [COORD_WIDTH-1:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 4))
         0: raw[FLAG_WIDTH-1:0] = '0;
         1: raw[FLAG_WIDTH-1:0] = '1;
         2: raw[FLAG_WIDTH-1:0] = {NUM_AXES{MODE_REFLECTING}};
         default: ;
      endcase
      return raw;
   endfunction

   initial begin
      idle_on = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: all periodic, 64.0 per axis
      send_particle(0, RESET_SPAN - 1, 32'h0001_0000, 0, -1, COORD_MAX);
      send_particle(-1, -32'sh0001_0000, -RESET_SPAN, 5, COORD_MIN, -3);
      send_particle(RESET_SPAN, RESET_SPAN + 5, COORD_MAX, -5, 7, 1);
      send_particle(COORD_MIN, COORD_MIN, RESET_SPAN - 1, 1, 1, 1);
      settle();

      // reflecting walls; lengths of one LSB, zero and the full range
      apply_setting(1, 0, 32'hFFFF_FFFF, 0,
                    {NUM_AXES{MODE_REFLECTING}}, {NUM_AXES{MODE_REFLECTING}});
      write_csr(CSR_UNMAPPED_LO, '1);
      write_csr(CSR_UNMAPPED_HI, '1);
      csr_we <= 1'b0;
      send_particle(-1, -1, -5, COORD_MIN, 5, -7);
      send_particle(5, 1, COORD_MIN, COORD_MIN, COORD_MAX, 0);
      send_particle(0, 0, COORD_MAX, 12345, -98765, COORD_MIN);
      settle();

      // mixed neighbours, absorbing codes on both sides
      apply_setting(COORD_WIDTH'(LEN_RESET), 32'h0000_1000, 32'h7FFF_FFFF, 32'h0000_0011,
                    32'({MODE_REFLECTING, MODE_ABSORB_ALT, MODE_ABSORBING}),
                    32'({MODE_ABSORB_ALT, MODE_ABSORBING, MODE_ABSORBING}));
      send_particle(-3, 32'h0000_0800, 10, 1, 2, 3);
      send_particle(0, -1, 0, 4, 5, 6);
      send_particle(0, 32'h0000_2000, 0, 7, 8, 9);
      send_particle(RESET_SPAN, 0, 0, -1, -2, -3);
      send_particle(0, 0, -1, 0, 0, COORD_MIN);
      send_particle(0, 0, COORD_MAX, 1, 1, 1);
      settle();

      // neighbours everywhere override absorbing modes
      apply_setting(32'h0001_0000, 32'h7FFF_FFFF, 1, 32'h0000_003F,
                    {NUM_AXES{MODE_ABSORB_ALT}}, {NUM_AXES{MODE_ABSORBING}});
      send_particle(COORD_MIN, COORD_MIN, COORD_MAX, 1, -1, 0);
      send_particle(COORD_MAX, -1, -1, COORD_MAX, COORD_MIN, 2);
      settle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         apply_setting(pick_length(), pick_length(), pick_length(),
                       pick_flag_word(), pick_flag_word(), pick_flag_word());
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            idle_on = (ph < RANDOM_PHASES - 1) && ((i / 32) % 3 != 2);
            send_particle(pick_coord(0), pick_coord(1), pick_coord(2),
                          pick_mom(), pick_mom(), pick_mom());
            if (ph == 1 && i == PHASE_ITEMS / 2)
               settle();
         end
         settle();
      end

      $display("Covered %0d particles under %0d boundary settings, %0d of them absorbed.",
               items_sent, settings_count, dropped_seen);
      $display("Wall, wrap, reflect and saturation cases first, then random beats with idling.");
      if (mismatch_count == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
